// ===== sv/wsdef_pkg.sv =====
`timescale 1ns / 1ps

package wsdef_pkg;

	localparam logic [3:0] DEFAULT_WINDOW_BITS = 4'd15;
	localparam logic [7:0] MIN_BITS = 8'd8;
	localparam logic [7:0] MAX_BITS = 8'd15;

	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_COMMA = 8'h2C;
	localparam logic [7:0] CHAR_SEMI = 8'h3B;
	localparam logic [7:0] CHAR_EQUALS = 8'h3D;
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;

	localparam int KW_COUNT = 5;
	localparam logic [2:0] KW_PMD = 3'd0;
	localparam logic [2:0] KW_SMWB = 3'd1;
	localparam logic [2:0] KW_CMWB = 3'd2;
	localparam logic [2:0] KW_SNCT = 3'd3;
	localparam logic [2:0] KW_CNCT = 3'd4;
	localparam logic [KW_COUNT-1:0] KW_ALL = '1;
	localparam logic [4:0] POS_MAX = 5'd31;

	localparam logic [17:0][7:0] PMD_TEXT = "permessage-deflate";
	localparam logic [21:0][7:0] SMWB_TEXT = {"server_max", "_window_bits"};
	localparam logic [21:0][7:0] CMWB_TEXT = {"client_max", "_window_bits"};
	localparam logic [25:0][7:0] SNCT_TEXT = {"server_no", "_context_takeover"};
	localparam logic [25:0][7:0] CNCT_TEXT = {"client_no", "_context_takeover"};

	localparam logic [1:0] STATUS_OK = 2'd0;
	localparam logic [1:0] STATUS_NOT_OFFERED = 2'd1;
	localparam logic [1:0] STATUS_INVALID = 2'd2;

	typedef struct packed {
		logic [4:0]          pos;
		logic [KW_COUNT-1:0] mask;
		logic                closed;
	} token_t;

	typedef struct packed {
		logic [1:0] status;
		logic [3:0] server_bits;
		logic [3:0] client_bits;
		logic       server_flag;
		logic       client_flag;
	} result_t;

	function automatic logic [4:0] kw_len(input logic [2:0] k);
		logic [4:0] len;
		len = 5'd0;
		unique case (k)
			KW_PMD: len = 5'd18;
			KW_SMWB, KW_CMWB: len = 5'd22;
			KW_SNCT, KW_CNCT: len = 5'd26;
			default: len = 5'd0;
		endcase
		return len;
	endfunction

	function automatic logic kw_hit(input logic [2:0] k, input logic [4:0] pos,
		input logic [7:0] c);
		logic [7:0] ch;
		logic       in_range;
		ch = 8'h00;
		in_range = pos < kw_len(k);
		unique case (k)
			KW_PMD: if (in_range) ch = PMD_TEXT[5'd17 - pos];
			KW_SMWB: if (in_range) ch = SMWB_TEXT[5'd21 - pos];
			KW_CMWB: if (in_range) ch = CMWB_TEXT[5'd21 - pos];
			KW_SNCT: if (in_range) ch = SNCT_TEXT[5'd25 - pos];
			KW_CNCT: if (in_range) ch = CNCT_TEXT[5'd25 - pos];
			default: ch = 8'h00;
		endcase
		return in_range && (ch == c);
	endfunction

	function automatic logic token_is(input token_t t, input logic [2:0] k);
		return t.mask[k] && (t.pos == kw_len(k));
	endfunction

endpackage

// ===== sv/wsdef_token_match.sv =====
`timescale 1ns / 1ps

module wsdef_token_match (
	input  wsdef_pkg::token_t tok,
	input  logic [7:0]        header_byte,
	output wsdef_pkg::token_t tok_next
);

	always_comb begin
		tok_next = tok;
		if (header_byte == wsdef_pkg::CHAR_SPACE) begin
			if (tok.pos != 5'd0)
				tok_next.closed = 1'b1;
		end else if (tok.closed) begin
			tok_next.mask = '0;
		end else begin
			for (int k = 0; k < wsdef_pkg::KW_COUNT; k++) begin
				if (!wsdef_pkg::kw_hit(3'(k), tok.pos, header_byte))
					tok_next.mask[k] = 1'b0;
			end
			if (tok.pos < wsdef_pkg::POS_MAX)
				tok_next.pos = tok.pos + 5'd1;
		end
	end

endmodule

// ===== sv/wsdef_parser.sv =====
`timescale 1ns / 1ps

module wsdef_parser #(
	parameter logic [3:0] DEFAULT_WINDOW_BITS = wsdef_pkg::DEFAULT_WINDOW_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          header_byte,
	input  logic                last_byte,
	output wsdef_pkg::result_t  result
);

	typedef enum logic [2:0] {
		PH_EXT_NAME,
		PH_SKIP_EXT,
		PH_PARAM,
		PH_VALUE,
		PH_DONE
	} phase_t;

	typedef struct packed {
		phase_t             phase;
		wsdef_pkg::token_t  tok;
		logic               equals_seen;
		logic [7:0]         num_value;
		logic               num_digit;
		logic               num_closed;
		logic               num_bad;
		logic               found;
		logic               error;
		logic [3:0]         server_bits;
		logic [3:0]         client_bits;
		logic               server_flag;
		logic               client_flag;
	} state_t;

	localparam wsdef_pkg::token_t TOKEN_INIT = '{pos: 5'd0, mask: wsdef_pkg::KW_ALL,
		closed: 1'b0};

	localparam state_t STATE_INIT = '{
		phase: PH_EXT_NAME,
		tok: TOKEN_INIT,
		equals_seen: 1'b0,
		num_value: 8'd0,
		num_digit: 1'b0,
		num_closed: 1'b0,
		num_bad: 1'b0,
		found: 1'b0,
		error: 1'b0,
		server_bits: DEFAULT_WINDOW_BITS,
		client_bits: DEFAULT_WINDOW_BITS,
		server_flag: 1'b0,
		client_flag: 1'b0
	};

	state_t            state_q;
	state_t            state_next;
	wsdef_pkg::token_t tok_fed;

	function automatic state_t close_param(input state_t s);
		state_t r;
		logic   ok;
		r = s;
		ok = s.num_digit && !s.num_bad && (s.num_value >= wsdef_pkg::MIN_BITS) &&
			(s.num_value <= wsdef_pkg::MAX_BITS);
		if (s.phase == PH_VALUE && !ok) begin
			r.found = 1'b1;
			r.error = 1'b1;
			r.phase = PH_DONE;
		end else begin
			if (s.phase == PH_PARAM && !s.equals_seen) begin
				if (wsdef_pkg::token_is(s.tok, wsdef_pkg::KW_SNCT))
					r.server_flag = 1'b1;
				if (wsdef_pkg::token_is(s.tok, wsdef_pkg::KW_CNCT))
					r.client_flag = 1'b1;
			end else if (s.phase == PH_VALUE) begin
				if (s.tok.mask[wsdef_pkg::KW_SMWB])
					r.server_bits = s.num_value[3:0];
				else
					r.client_bits = s.num_value[3:0];
			end
			r.tok = TOKEN_INIT;
			r.equals_seen = 1'b0;
			r.num_value = 8'd0;
			r.num_digit = 1'b0;
			r.num_closed = 1'b0;
			r.num_bad = 1'b0;
			r.phase = PH_PARAM;
		end
		return r;
	endfunction

	function automatic state_t close_ext(input state_t s);
		state_t r;
		r = s;
		unique case (s.phase)
			PH_EXT_NAME: begin
				if (wsdef_pkg::token_is(s.tok, wsdef_pkg::KW_PMD)) begin
					r.found = 1'b1;
					r.phase = PH_DONE;
				end else begin
					r.tok = TOKEN_INIT;
				end
			end
			PH_SKIP_EXT: begin
				r.tok = TOKEN_INIT;
				r.phase = PH_EXT_NAME;
			end
			PH_PARAM, PH_VALUE: begin
				r = close_param(s);
				if (r.phase != PH_DONE) begin
					r.found = 1'b1;
					r.phase = PH_DONE;
				end
			end
			default: r = s;
		endcase
		return r;
	endfunction

	wsdef_token_match u_match (
		.tok         (state_q.tok),
		.header_byte (header_byte),
		.tok_next    (tok_fed)
	);

	always_comb begin
		state_t     s;
		state_t     fin;
		logic [11:0] acc;
		s = state_q;
		fin = state_q;
		acc = 12'({4'd0, state_q.num_value} * 12'd10) + {8'd0, header_byte[3:0]};
		if (header_byte == wsdef_pkg::CHAR_COMMA) begin
			s = close_ext(state_q);
		end else if (header_byte == wsdef_pkg::CHAR_SEMI) begin
			if (state_q.phase == PH_EXT_NAME) begin
				if (wsdef_pkg::token_is(state_q.tok, wsdef_pkg::KW_PMD)) begin
					s.tok = TOKEN_INIT;
					s.phase = PH_PARAM;
				end else begin
					s.phase = PH_SKIP_EXT;
				end
			end else if (state_q.phase == PH_PARAM || state_q.phase == PH_VALUE) begin
				s = close_param(state_q);
			end
		end else if (state_q.phase == PH_EXT_NAME) begin
			s.tok = tok_fed;
		end else if (state_q.phase == PH_PARAM) begin
			if (!state_q.equals_seen) begin
				if (header_byte == wsdef_pkg::CHAR_EQUALS) begin
					if (wsdef_pkg::token_is(state_q.tok, wsdef_pkg::KW_SMWB)) begin
						s.tok.mask = wsdef_pkg::KW_COUNT'(1) << wsdef_pkg::KW_SMWB;
						s.phase = PH_VALUE;
					end else if (wsdef_pkg::token_is(state_q.tok, wsdef_pkg::KW_CMWB)) begin
						s.tok.mask = wsdef_pkg::KW_COUNT'(1) << wsdef_pkg::KW_CMWB;
						s.phase = PH_VALUE;
					end else begin
						s.equals_seen = 1'b1;
					end
				end else begin
					s.tok = tok_fed;
				end
			end
		end else if (state_q.phase == PH_VALUE) begin
			if (header_byte == wsdef_pkg::CHAR_SPACE) begin
				if (state_q.num_digit)
					s.num_closed = 1'b1;
			end else if (header_byte >= wsdef_pkg::CHAR_ZERO &&
				header_byte <= wsdef_pkg::CHAR_NINE) begin
				if (state_q.num_closed || acc > 12'd255)
					s.num_bad = 1'b1;
				s.num_value = acc[7:0];
				s.num_digit = 1'b1;
			end else begin
				s.num_bad = 1'b1;
			end
		end

		fin = close_ext(s);
		result.server_bits = DEFAULT_WINDOW_BITS;
		result.client_bits = DEFAULT_WINDOW_BITS;
		result.server_flag = 1'b0;
		result.client_flag = 1'b0;
		if (fin.phase != PH_DONE) begin
			result.status = wsdef_pkg::STATUS_NOT_OFFERED;
		end else if (fin.error) begin
			result.status = wsdef_pkg::STATUS_INVALID;
		end else begin
			result.status = wsdef_pkg::STATUS_OK;
			result.server_bits = fin.server_bits;
			result.client_bits = fin.client_bits;
			result.server_flag = fin.server_flag;
			result.client_flag = fin.client_flag;
		end

		state_next = last_byte ? STATE_INIT : s;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_INIT;
		end else if (step) begin
			state_q <= state_next;
		end
	end

endmodule

// ===== sv/ws_deflate_extension_header_parser.sv =====
`timescale 1ns / 1ps

// Extensions header parser for the permessage-deflate offer.
// Header channel: one character per transfer on header_byte, last_byte marks
// the final character; header_valid / header_stall handshake.
// Result channel: one transfer per header on result_valid / result_stall,
// carrying status, both window-bits values and both no-takeover flags.
// Latency: a character enters the input register when it is transferred; the
// parse step runs from that register into the state and result registers, so
// the result of a header is registered from the held last character, and
// result_valid rises once it reaches the result register.
// Throughput: one character per cycle while header_stall is low; the parse
// step: keyword compare, a small decimal accumulate and segment-close logic.
// A stalled result holds; one more result waits in a spare register, and only
// when both are full does a last character wait in the input register with
// header_stall high. Other characters keep moving while results wait.
// Reset clears the handshake state and returns the parser to the start of a
// header; after each result the parser restarts for the next header.

module ws_deflate_extension_header_parser #(
	parameter logic [3:0] DEFAULT_WINDOW_BITS = wsdef_pkg::DEFAULT_WINDOW_BITS
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       header_valid,
	output logic       header_stall,
	input  logic [7:0] header_byte,
	input  logic       last_byte,
	output logic       result_valid,
	input  logic       result_stall,
	output logic [1:0] status,
	output logic [3:0] server_window_bits,
	output logic [3:0] client_window_bits,
	output logic       server_no_takeover,
	output logic       client_no_takeover
);

	logic               valid_s1;
	logic [7:0]         byte_s1;
	logic               last_s1;
	logic               move_s1;
	logic               accept;
	logic               load_result;
	wsdef_pkg::result_t result_comb;
	wsdef_pkg::result_t result_q;
	logic               result_valid_q;
	wsdef_pkg::result_t spare_q;
	logic               spare_valid_q;

	assign move_s1 = valid_s1 && (!last_s1 || !spare_valid_q);
	assign header_stall = valid_s1 && !move_s1;
	assign accept = header_valid && !header_stall;
	assign load_result = move_s1 && last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (move_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= header_byte;
			last_s1 <= last_byte;
		end
	end

	wsdef_parser #(
		.DEFAULT_WINDOW_BITS (DEFAULT_WINDOW_BITS)
	) u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (move_s1),
		.header_byte (byte_s1),
		.last_byte   (last_s1),
		.result      (result_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
			spare_valid_q <= 1'b0;
		end else if (result_valid_q && result_stall) begin
			if (load_result)
				spare_valid_q <= 1'b1;
		end else begin
			result_valid_q <= spare_valid_q || load_result;
			spare_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (result_valid_q && result_stall) begin
			if (load_result)
				spare_q <= result_comb;
		end else if (spare_valid_q) begin
			result_q <= spare_q;
		end else if (load_result) begin
			result_q <= result_comb;
		end
	end

	assign result_valid = result_valid_q;
	assign status = result_q.status;
	assign server_window_bits = result_q.server_bits;
	assign client_window_bits = result_q.client_bits;
	assign server_no_takeover = result_q.server_flag;
	assign client_no_takeover = result_q.client_flag;

`ifndef SYNTHESIS
	a_stall_needs_held_item: assert property (@(posedge clk) disable iff (!arst_n)
		header_stall |-> valid_s1 && last_s1)
		else $error("header stalled without a held last character");

	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(valid_s1 && last_s1))
		else $error("result raised without a last character");

	a_ok_bits_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status == wsdef_pkg::STATUS_OK |->
		server_window_bits >= 4'd8 && client_window_bits >= 4'd8)
		else $error("accepted header with window bits below range");

	a_fail_defaults: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status != wsdef_pkg::STATUS_OK |->
		server_window_bits == DEFAULT_WINDOW_BITS &&
		client_window_bits == DEFAULT_WINDOW_BITS &&
		!server_no_takeover && !client_no_takeover)
		else $error("failed header carries non-default settings");
`endif

endmodule

// ===== verif/tb_ws_deflate_extension_header_parser.sv =====
`timescale 1ns / 1ps

module tb_ws_deflate_extension_header_parser;

	typedef logic [7:0] char_q_t [$];
	typedef enum logic [2:0] {PH_NAME, PH_SKIP, PH_PARAM, PH_VALUE, PH_DONE} parse_phase_t;

	logic       clk;
	logic       arst_n;
	logic       header_valid;
	logic       header_stall;
	logic [7:0] header_byte;
	logic       last_byte;
	logic       result_valid;
	logic       result_stall;
	logic [1:0] status;
	logic [3:0] server_window_bits;
	logic [3:0] client_window_bits;
	logic       server_no_takeover;
	logic       client_no_takeover;

	bit          quiet_run = 1'b0;
	int unsigned error_count = 0;
	int unsigned chars_sent = 0;

	string kw_word [wsdef_pkg::KW_COUNT] = '{"permessage-deflate",
		{"server_max", "_window_bits"}, {"client_max", "_window_bits"},
		{"server_no", "_context_takeover"}, {"client_no", "_context_takeover"}};

	parse_phase_t                  parse_phase;
	int unsigned                   tok_pos;
	logic [wsdef_pkg::KW_COUNT-1:0] tok_mask;
	logic                          tok_closed;
	logic                          eq_seen;
	int unsigned                   num_val;
	logic                          num_digit;
	logic                          num_closed;
	logic                          num_bad;
	logic                          offer_found;
	logic                          offer_bad;
	logic [3:0]                    srv_bits;
	logic [3:0]                    cli_bits;
	logic                          srv_flag;
	logic                          cli_flag;
	wsdef_pkg::result_t            expected_offers [$];

	ws_deflate_extension_header_parser u_top (
		.clk(clk),
		.arst_n(arst_n),
		.header_valid(header_valid),
		.header_stall(header_stall),
		.header_byte(header_byte),
		.last_byte(last_byte),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.status(status),
		.server_window_bits(server_window_bits),
		.client_window_bits(client_window_bits),
		.server_no_takeover(server_no_takeover),
		.client_no_takeover(client_no_takeover)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function void clear_token();
		tok_pos = 0;
		tok_mask = wsdef_pkg::KW_ALL;
		tok_closed = 1'b0;
	endfunction

	function void clear_number();
		eq_seen = 1'b0;
		num_val = 0;
		num_digit = 1'b0;
		num_closed = 1'b0;
		num_bad = 1'b0;
	endfunction

	function void restart_parser();
		parse_phase = PH_NAME;
		clear_token();
		clear_number();
		offer_found = 1'b0;
		offer_bad = 1'b0;
		srv_bits = wsdef_pkg::DEFAULT_WINDOW_BITS;
		cli_bits = wsdef_pkg::DEFAULT_WINDOW_BITS;
		srv_flag = 1'b0;
		cli_flag = 1'b0;
	endfunction

	function logic token_matches(input int k);
		return tok_mask[k] && tok_pos == kw_word[k].len();
	endfunction

	function void feed_name(input logic [7:0] c);
		if (c == wsdef_pkg::CHAR_SPACE) begin
			if (tok_pos > 0)
				tok_closed = 1'b1;
			return;
		end
		if (tok_closed) begin
			tok_mask = '0;
			return;
		end
		for (int k = 0; k < wsdef_pkg::KW_COUNT; k++)
			if (tok_pos >= kw_word[k].len() || 8'(kw_word[k][tok_pos]) != c)
				tok_mask[k] = 1'b0;
		if (tok_pos < 31)
			tok_pos++;
	endfunction

	function void feed_number(input logic [7:0] c);
		int unsigned v;
		if (c == wsdef_pkg::CHAR_SPACE) begin
			if (num_digit)
				num_closed = 1'b1;
		end else if (c >= wsdef_pkg::CHAR_ZERO && c <= wsdef_pkg::CHAR_NINE) begin
			v = num_val * 10 + (c - wsdef_pkg::CHAR_ZERO);
			if (num_closed || v > 255)
				num_bad = 1'b1;
			num_val = v & 255;
			num_digit = 1'b1;
		end else begin
			num_bad = 1'b1;
		end
	endfunction

	function void end_param();
		if (parse_phase == PH_PARAM) begin
			if (!eq_seen) begin
				if (token_matches(wsdef_pkg::KW_SNCT))
					srv_flag = 1'b1;
				if (token_matches(wsdef_pkg::KW_CNCT))
					cli_flag = 1'b1;
			end
		end else if (parse_phase == PH_VALUE) begin
			if (!num_digit || num_bad || num_val < wsdef_pkg::MIN_BITS ||
				num_val > wsdef_pkg::MAX_BITS) begin
				offer_found = 1'b1;
				offer_bad = 1'b1;
				parse_phase = PH_DONE;
				return;
			end
			if (tok_mask[wsdef_pkg::KW_SMWB])
				srv_bits = 4'(num_val);
			else
				cli_bits = 4'(num_val);
		end
		clear_token();
		clear_number();
		parse_phase = PH_PARAM;
	endfunction

	function void end_extension();
		case (parse_phase)
			PH_NAME: begin
				if (token_matches(wsdef_pkg::KW_PMD)) begin
					offer_found = 1'b1;
					parse_phase = PH_DONE;
				end else begin
					clear_token();
				end
			end
			PH_SKIP: begin
				clear_token();
				parse_phase = PH_NAME;
			end
			PH_PARAM, PH_VALUE: begin
				end_param();
				if (parse_phase != PH_DONE) begin
					offer_found = 1'b1;
					parse_phase = PH_DONE;
				end
			end
			default: ;
		endcase
	endfunction

	function void predict_offer_byte(input logic [7:0] c, input logic lst);
		wsdef_pkg::result_t r;
		if (c == wsdef_pkg::CHAR_COMMA) begin
			end_extension();
		end else if (c == wsdef_pkg::CHAR_SEMI) begin
			if (parse_phase == PH_NAME) begin
				if (token_matches(wsdef_pkg::KW_PMD)) begin
					clear_token();
					parse_phase = PH_PARAM;
				end else begin
					parse_phase = PH_SKIP;
				end
			end else if (parse_phase == PH_PARAM || parse_phase == PH_VALUE) begin
				end_param();
			end
		end else if (parse_phase == PH_NAME) begin
			feed_name(c);
		end else if (parse_phase == PH_PARAM) begin
			if (!eq_seen) begin
				if (c == wsdef_pkg::CHAR_EQUALS) begin
					if (token_matches(wsdef_pkg::KW_SMWB)) begin
						tok_mask = wsdef_pkg::KW_COUNT'(1) << wsdef_pkg::KW_SMWB;
						parse_phase = PH_VALUE;
					end else if (token_matches(wsdef_pkg::KW_CMWB)) begin
						tok_mask = wsdef_pkg::KW_COUNT'(1) << wsdef_pkg::KW_CMWB;
						parse_phase = PH_VALUE;
					end else begin
						eq_seen = 1'b1;
					end
				end else begin
					feed_name(c);
				end
			end
		end else if (parse_phase == PH_VALUE) begin
			feed_number(c);
		end
		if (!lst)
			return;
		end_extension();
		if (parse_phase != PH_DONE)
			r.status = wsdef_pkg::STATUS_NOT_OFFERED;
		else if (offer_bad)
			r.status = wsdef_pkg::STATUS_INVALID;
		else
			r.status = wsdef_pkg::STATUS_OK;
		r.server_bits = (r.status == wsdef_pkg::STATUS_OK) ? srv_bits :
			wsdef_pkg::DEFAULT_WINDOW_BITS;
		r.client_bits = (r.status == wsdef_pkg::STATUS_OK) ? cli_bits :
			wsdef_pkg::DEFAULT_WINDOW_BITS;
		r.server_flag = (r.status == wsdef_pkg::STATUS_OK) ? srv_flag : 1'b0;
		r.client_flag = (r.status == wsdef_pkg::STATUS_OK) ? cli_flag : 1'b0;
		expected_offers.push_back(r);
		restart_parser();
	endfunction

	task report_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $time, msg);
		error_count++;
	endtask

	always @(posedge clk) begin : result_check
		wsdef_pkg::result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_offers.size() == 0) begin
				report_mismatch("result transfer with no header pending");
			end else begin
				want = expected_offers.pop_front();
				if (status !== want.status)
					report_mismatch($sformatf("status %0d, want %0d", status, want.status));
				if (server_window_bits !== want.server_bits)
					report_mismatch($sformatf("server_window_bits %0d, want %0d",
						server_window_bits, want.server_bits));
				if (client_window_bits !== want.client_bits)
					report_mismatch($sformatf("client_window_bits %0d, want %0d",
						client_window_bits, want.client_bits));
				if (server_no_takeover !== want.server_flag)
					report_mismatch($sformatf("server_no_takeover %0b, want %0b",
						server_no_takeover, want.server_flag));
				if (client_no_takeover !== want.client_flag)
					report_mismatch($sformatf("client_no_takeover %0b, want %0b",
						client_no_takeover, want.client_flag));
			end
		end
	end

	// hold result_stall in random bursts
	initial begin
		result_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (!quiet_run && $urandom_range(0, 4) == 0) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				result_stall <= 1'b0;
			end
		end
	end

	task automatic send_char(input logic [7:0] c, input logic lst);
		if (!quiet_run && $urandom_range(0, 5) == 0) begin
			header_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		header_valid <= 1'b1;
		header_byte <= c;
		last_byte <= lst;
		do @(posedge clk); while (header_stall);
		predict_offer_byte(c, lst);
		chars_sent++;
	endtask

	task automatic send_header(input char_q_t q);
		foreach (q[i])
			send_char(q[i], i == q.size() - 1);
	endtask

	function automatic char_q_t text_chars(input string s);
		char_q_t q;
		for (int i = 0; i < s.len(); i++)
			q.push_back(8'(s[i]));
		return q;
	endfunction

	task automatic send_text(input string s);
		send_header(text_chars(s));
	endtask

	function automatic string pick_spaces();
		case ($urandom_range(0, 5))
			0: return " ";
			1: return "  ";
			default: return "";
		endcase
	endfunction

	function automatic string garble(input string s);
		string g;
		g = s;
		g.putc($urandom_range(0, s.len() - 1), 8'($urandom_range(33, 126)));
		return g;
	endfunction

	function automatic string window_value();
		string odd_values [10] = '{"", "1 2", "0009", "1a", "=9", " 12 ", "x", "2555",
			"00000000012", "256"};
		int unsigned pick;
		pick = $urandom_range(0, 11);
		if (pick < 7)
			return $sformatf("%0d", $urandom_range(8, 15));
		case (pick)
			7: return $sformatf("%0d", $urandom_range(0, 7));
			8: return $sformatf("%0d", $urandom_range(16, 400));
			default: return odd_values[$urandom_range(0, 9)];
		endcase
	endfunction

	function automatic string offer_param();
		case ($urandom_range(0, 10))
			0, 1: return {kw_word[wsdef_pkg::KW_SMWB], pick_spaces(), "=", pick_spaces(),
				window_value()};
			2, 3: return {kw_word[wsdef_pkg::KW_CMWB], pick_spaces(), "=", pick_spaces(),
				window_value()};
			4: return kw_word[wsdef_pkg::KW_SNCT];
			5: return kw_word[wsdef_pkg::KW_CNCT];
			6: return kw_word[$urandom_range(wsdef_pkg::KW_SMWB, wsdef_pkg::KW_CMWB)];
			7: return {kw_word[$urandom_range(wsdef_pkg::KW_SNCT, wsdef_pkg::KW_CNCT)], "=",
				window_value()};
			8: return {garble(kw_word[$urandom_range(wsdef_pkg::KW_SMWB, wsdef_pkg::KW_CNCT)]),
				"=", window_value()};
			9: return "x_opt";
			default: return {"x_opt", pick_spaces(), "=", pick_spaces(), "a=b"};
		endcase
	endfunction

	function automatic string ext_name_text();
		case ($urandom_range(0, 8))
			0: return "x-webkit-deflate-frame";
			1: return garble(kw_word[wsdef_pkg::KW_PMD]);
			2: return "permessage-deflat";
			3: return "permessage - deflate";
			default: return kw_word[wsdef_pkg::KW_PMD];
		endcase
	endfunction

	function automatic string offer_header();
		string h;
		h = "";
		for (int e = $urandom_range(1, 3); e > 0; e--) begin
			h = {h, pick_spaces(), ext_name_text(), pick_spaces()};
			repeat ($urandom_range(0, 3))
				h = {h, ";", pick_spaces(), offer_param(), pick_spaces()};
			if (e > 1)
				h = {h, ","};
		end
		if ($urandom_range(0, 9) == 0)
			h = {h, $urandom_range(0, 1) ? "," : ";"};
		return h;
	endfunction

	task automatic send_random_header();
		char_q_t q;
		int unsigned kind;
		kind = $urandom_range(0, 19);
		if (kind < 3) begin
			repeat ($urandom_range(1, 24)) begin
				case ($urandom_range(0, 5))
					0: q.push_back(wsdef_pkg::CHAR_COMMA);
					1: q.push_back(wsdef_pkg::CHAR_SEMI);
					2: q.push_back(wsdef_pkg::CHAR_EQUALS);
					3: q.push_back(wsdef_pkg::CHAR_SPACE);
					default: q.push_back(8'($urandom));
				endcase
			end
		end else begin
			q = text_chars(offer_header());
			if (kind < 6) begin
				if ($urandom_range(0, 1))
					q[$urandom_range(0, q.size() - 1)] = 8'($urandom);
				else
					q = q[0:$urandom_range(0, q.size() - 1)];
			end
		end
		send_header(q);
	endtask

	task automatic test_offer_basics();
		char_q_t q;
		string   snct;
		string   cnct;
		snct = kw_word[wsdef_pkg::KW_SNCT];
		cnct = kw_word[wsdef_pkg::KW_CNCT];
		q = '{8'h00};
		send_header(q);
		q = '{8'hFF};
		send_header(q);
		send_text("x");
		send_text("permessage-deflate");
		send_text("Permessage-deflate");
		send_text("  permessage-deflate  ");
		send_text("permessage-deflate x");
		send_text({"x-foo, permessage-deflate; ", cnct});
		send_text({"x-foo;permessage-deflate, permessage-deflate;", snct});
		send_text("permessage-deflate,");
		send_text("x-foo;");
	endtask

	task automatic test_window_values();
		string smwb;
		string cmwb;
		smwb = kw_word[wsdef_pkg::KW_SMWB];
		cmwb = kw_word[wsdef_pkg::KW_CMWB];
		send_text({"permessage-deflate; ", smwb, "=8"});
		send_text({"permessage-deflate; ", cmwb, " = 15 "});
		send_text({"permessage-deflate;", smwb, "=7"});
		send_text({"permessage-deflate;", cmwb, "=16"});
		send_text({"permessage-deflate;", smwb, "=256"});
		send_text({"permessage-deflate;", smwb, "="});
		send_text({"permessage-deflate;", cmwb, "=1 2"});
		send_text({"permessage-deflate;", cmwb, "=1a"});
		send_text({"permessage-deflate;", smwb, "=9="});
		send_text({"permessage-deflate;", smwb, "=0012;", smwb, "=9"});
		send_text({"permessage-deflate;", smwb, "=99, permessage-deflate"});
	endtask

	task automatic test_flags_and_unknown();
		string smwb;
		string cmwb;
		string snct;
		string cnct;
		smwb = kw_word[wsdef_pkg::KW_SMWB];
		cmwb = kw_word[wsdef_pkg::KW_CMWB];
		snct = kw_word[wsdef_pkg::KW_SNCT];
		cnct = kw_word[wsdef_pkg::KW_CNCT];
		send_text({"permessage-deflate;", snct, ";", cnct, ";"});
		send_text({"permessage-deflate; ", smwb, "; ", cmwb, "=10"});
		send_text({"permessage-deflate; ", cnct, "=1"});
		send_text({"permessage-deflate; x_opt=abc; ", cmwb, "=11, x-bar=1"});
	endtask

	task automatic test_random_headers();
		while (chars_sent < 1150)
			send_random_header();
	endtask

	task automatic test_steady_stream();
		quiet_run = 1'b1;
		while (chars_sent < 1400)
			send_random_header();
	endtask

	initial begin
		arst_n <= 1'b0;
		header_valid <= 1'b0;
		header_byte <= '0;
		last_byte <= 1'b0;
		restart_parser();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_offer_basics();
		test_window_values();
		test_flags_and_unknown();
		test_random_headers();
		test_steady_stream();
		header_valid <= 1'b0;
		while (expected_offers.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (error_count == 0)
			$display("tb_ws_deflate_extension_header_parser: clean");
		else
			$display("tb_ws_deflate_extension_header_parser: errors");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("tb_ws_deflate_extension_header_parser: errors");
		$finish;
	end

endmodule
